>>> rtl/core/assert_macros.svh
// assertion helpers for the sorted set table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge, reset included
`define SST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// checked only outside reset
`define SST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

>>> rtl/core/sst_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sst_pkg
// shared types and codes of the sorted set table
// ---------------------------------------------------------------------------
package sst_pkg;

  localparam int DEFAULT_CAPACITY = 64;
  localparam int VAL_W            = 32;
  localparam int ACT_W            = 2;
  localparam int STAT_W           = 2;
  localparam int CNT_OUT_W        = 7;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } cell_cmd_t;

endpackage

>>> rtl/core/sst_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sst_cell
// one table slot: compares against the broadcast word and shifts with its
// neighbors on insert or delete
// ---------------------------------------------------------------------------
module sst_cell
  import sst_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  logic                    clk,
  input  cell_cmd_t               cmd,
  input  logic signed [VAL_W-1:0] bcast,
  input  logic [CNT_W-1:0]        count,
  input  logic                    left_lt,
  input  logic signed [VAL_W-1:0] left_entry,
  input  logic signed [VAL_W-1:0] right_entry,
  output logic signed [VAL_W-1:0] entry,
  output logic                    lt,
  output logic                    hit
);

  logic valid;

  assign valid = CNT_W'(INDEX) < count;

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      lt  <= valid && (entry < bcast);
      hit <= valid && (entry == bcast);
    end
    // slots below the position keep their word
    if (cmd.ins && !lt) begin
      entry <= left_lt ? bcast : left_entry;
    end
    if (cmd.del && !lt) begin
      entry <= right_entry;
    end
  end

endmodule

>>> rtl/core/sorted_set_table_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_set_table_top
// ascending set of distinct signed words held in a row of compare and
// shift cells
// ---------------------------------------------------------------------------
//  channel   handshake       payload
//  request   start / busy    action, value
//  result    done strobe     status, entry_count
//
//  the accept edge of a request compares the word against every cell at once,
//  the next edge shifts the row and registers the result. busy is high between
//  those edges, and no new request is taken while busy is high.
//  done is high for one cycle; the receiver cannot stall it.
//  rst (synchronous) clears the count; table contents need no clearing.
module sorted_set_table_top
  import sst_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [ACT_W-1:0]        action,
  input  logic signed [VAL_W-1:0] value,
  output logic                    done,
  output logic [STAT_W-1:0]       status,
  output logic [CNT_OUT_W-1:0]    entry_count
);

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                    accept;
  logic [ACT_W-1:0]        act_q;
  logic signed [VAL_W-1:0] val_q;
  logic signed [VAL_W-1:0] bcast;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [STAT_W-1:0]       status_next;
  logic                    found;
  logic                    full;
  cell_cmd_t               cmd;

  logic signed [VAL_W-1:0] ent [CAPACITY];
  logic [CAPACITY-1:0]     lt;
  logic [CAPACITY-1:0]     hit;

  assign accept = start && !busy;
  assign bcast  = busy ? val_q : value;
  assign found  = |hit;
  assign full   = count == CNT_W'(CAPACITY);

  always_comb begin
    status_next = ST_MISS;
    count_next  = count;
    cmd.cmp     = accept;
    cmd.ins     = 1'b0;
    cmd.del     = 1'b0;
    if (busy) begin
      unique case (act_q)
        ACT_INSERT: begin
          if (found) begin
            status_next = ST_MISS;
          end else if (full) begin
            status_next = ST_FULL;
          end else begin
            status_next = ST_OK;
            count_next  = count + CNT_W'(1);
            cmd.ins     = 1'b1;
          end
        end
        ACT_DELETE: begin
          if (found) begin
            status_next = ST_OK;
            count_next  = count - CNT_W'(1);
            cmd.del     = 1'b1;
          end
        end
        ACT_SEARCH: begin
          if (found) begin
            status_next = ST_OK;
          end
        end
        default: begin
          status_next = ST_MISS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      busy <= accept;
      done <= busy;
      if (busy) begin
        count       <= count_next;
        status      <= status_next;
        entry_count <= CNT_OUT_W'(count_next);
      end
    end
    if (accept) begin
      act_q <= action;
      val_q <= value;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sst_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .bcast       (bcast),
      .count       (count),
      .left_lt     ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i - 1]),
      .left_entry  (ent[(i == 0) ? 0 : i - 1]),
      .right_entry (ent[(i == CAPACITY - 1) ? i : i + 1]),
      .entry       (ent[i]),
      .lt          (lt[i]),
      .hit         (hit[i])
    );
  end

  `SST_ASSERT_ALWAYS(a_rst_idle, rst |=> (!busy && !done), "not idle after reset")
  `SST_ASSERT(a_busy_done, busy |=> done, "apply cycle gave no result")
  `SST_ASSERT(a_cnt_bound, count <= CNT_W'(CAPACITY), "entry count above capacity")
  `SST_ASSERT(a_full_stat, (done && status == ST_FULL) |-> (count == CNT_W'(CAPACITY)), "full status on a table with room")
  `SST_ASSERT(a_cnt_change, (!$past(rst) && !$stable(count)) |-> done, "count moved without a result")

endmodule
